// ===== design/csar_pkg.sv =====
package csar_pkg;

   // Range codes
   localparam logic [2:0] RANGE_400MA  = 3'd0;
   localparam logic [2:0] RANGE_800MA  = 3'd1;
   localparam logic [2:0] RANGE_1600MA = 3'd2;
   localparam logic [2:0] RANGE_2000MA = 3'd3;
   localparam logic [2:0] RANGE_3200MA = 3'd4;

   localparam logic [2:0] RANGE_RESET = RANGE_2000MA;

   // Calibration words per range
   localparam logic [15:0] CALIB_400MA  = 16'd33554;
   localparam logic [15:0] CALIB_800MA  = 16'd16778;
   localparam logic [15:0] CALIB_1600MA = 16'd8308;
   localparam logic [15:0] CALIB_2000MA = 16'd6710;
   localparam logic [15:0] CALIB_3200MA = 16'd4196;

   // Current thresholds in 1/32768 mA units
   localparam logic signed [29:0] LIMIT_2000MA = 30'sd65536000;
   localparam logic signed [29:0] LIMIT_1600MA = 30'sd52428800;
   localparam logic signed [29:0] LIMIT_800MA  = 30'sd26214400;
   localparam logic signed [29:0] LIMIT_400MA  = 30'sd13107200;

   // Bus range threshold in mV
   localparam logic signed [17:0] LIMIT_16V = 18'sd16000;

   typedef struct packed {
      logic [15:0] calibration_word;
      logic [15:0] config_word;
      logic [2:0]  range_code;
   } result_type;

   // Full scale in mA; unused codes read as the largest range
   function automatic logic [11:0] full_scale(input logic [2:0] range);
      logic [11:0] fs;
      case (range)
         RANGE_400MA:  fs = 12'd400;
         RANGE_800MA:  fs = 12'd800;
         RANGE_1600MA: fs = 12'd1600;
         RANGE_2000MA: fs = 12'd2000;
         default:      fs = 12'd3200;
      endcase
      return fs;
   endfunction

   function automatic logic [15:0] calib_word(input logic [2:0] range);
      logic [15:0] cw;
      case (range)
         RANGE_400MA:  cw = CALIB_400MA;
         RANGE_800MA:  cw = CALIB_800MA;
         RANGE_1600MA: cw = CALIB_1600MA;
         RANGE_2000MA: cw = CALIB_2000MA;
         default:      cw = CALIB_3200MA;
      endcase
      return cw;
   endfunction

   // PGA gain field (gain minus one)
   function automatic logic [1:0] gain_bits(input logic [2:0] range);
      logic [1:0] g;
      case (range)
         RANGE_400MA:  g = 2'd0;
         RANGE_800MA:  g = 2'd1;
         RANGE_1600MA: g = 2'd2;
         default:      g = 2'd3;
      endcase
      return g;
   endfunction

endpackage

// ===== design/csar_calc.sv =====
module csar_calc (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic signed [15:0]     current_raw,
   input  logic [15:0]            bus_raw,
   input  logic [15:0]            config_now,
   output csar_pkg::result_type   result
);

   logic [2:0]          active_range_ff, active_range_in;
   logic signed [27:0]  prev_current_ff, prev_current_in;
   logic [14:0]         prev_voltage_ff, prev_voltage_in;

   logic signed [28:0]  product;
   logic signed [27:0]  current;
   logic signed [29:0]  cur_pred;
   logic [14:0]         voltage;
   logic signed [17:0]  volt_pred;
   logic [2:0]          range;
   logic                sel_32v;

   // Scale current by the active full scale
   assign product = current_raw * $signed({1'b0, csar_pkg::full_scale(active_range_ff)});
   assign current = product[27:0];
   assign cur_pred = (30'(current) <<< 1) - 30'(prev_current_ff);

   // Bus voltage in mV: 4 mV per LSB of bits 15:3
   assign voltage   = {bus_raw[15:3], 2'b00};
   assign volt_pred = $signed({2'b00, voltage, 1'b0}) - $signed({3'b000, prev_voltage_ff});

   // Range selection, strict compares from the top down
   always_comb begin
      if (cur_pred > csar_pkg::LIMIT_2000MA) begin
         range = csar_pkg::RANGE_3200MA;
      end else if (cur_pred > csar_pkg::LIMIT_1600MA) begin
         range = csar_pkg::RANGE_2000MA;
      end else if (cur_pred > csar_pkg::LIMIT_800MA) begin
         range = csar_pkg::RANGE_1600MA;
      end else if (cur_pred > csar_pkg::LIMIT_400MA) begin
         range = csar_pkg::RANGE_800MA;
      end else begin
         range = csar_pkg::RANGE_400MA;
      end
   end

   assign sel_32v = (volt_pred > csar_pkg::LIMIT_16V);

   // Result assembly
   always_comb begin
      result.calibration_word = csar_pkg::calib_word(range);
      result.config_word      = {config_now[15:14], sel_32v,
                                 csar_pkg::gain_bits(range), config_now[10:0]};
      result.range_code       = range;
   end

   // History update when a request is processed
   always_comb begin
      active_range_in = active_range_ff;
      prev_current_in = prev_current_ff;
      prev_voltage_in = prev_voltage_ff;
      if (step) begin
         active_range_in = range;
         prev_current_in = current;
         prev_voltage_in = voltage;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_range_ff <= csar_pkg::RANGE_RESET;
         prev_current_ff <= '0;
         prev_voltage_ff <= '0;
      end else begin
         active_range_ff <= active_range_in;
         prev_current_ff <= prev_current_in;
         prev_voltage_ff <= prev_voltage_in;
      end
   end

endmodule

// ===== design/current_sensor_auto_ranger.sv =====
// Current sensor auto-ranger.
// Request channel (req_*): one sensor sample per request, the signed raw
// current word, the raw bus-voltage word and the present configuration word.
// Response channel (rsp_*): one response per request, in order, holding the
// calibration word, the updated configuration word and the chosen range code.
// Both channels use valid/ready; a transfer happens when both are high.
// A request is taken into the input register and its response then written
// to the result register, which drives rsp_valid. Throughput: one request
// per cycle while the receiver does not stall. Each sample is processed in
// the cycle it leaves the input register: one 16x13 multiply, a subtract
// and the range compares, which also update the range and history for the
// next sample. When the receiver stalls the response holds in the result
// register while one more request is still taken into the input register;
// req_ready drops only when both registers are full.
// Reset (synchronous, active high) empties both registers, sets the active
// range to 2000 mA and clears the current and voltage history.
module current_sensor_auto_ranger (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_current_raw,
   input  logic [15:0]        req_bus_raw,
   input  logic [15:0]        req_config_now,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_calibration_word,
   output logic [15:0]        rsp_config_word,
   output logic [2:0]         rsp_range_code
);

   logic                   in_valid_ff, in_valid_in;
   logic signed [15:0]     current_raw_ff, current_raw_in;
   logic [15:0]            bus_raw_ff, bus_raw_in;
   logic [15:0]            config_now_ff, config_now_in;
   logic                   out_valid_ff, out_valid_in;
   csar_pkg::result_type   result_ff, result_in;
   csar_pkg::result_type   calc_result;
   logic                   out_free;
   logic                   advance;
   logic                   req_fire;

   // Handshake control
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   csar_calc u_calc (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .current_raw (current_raw_ff),
      .bus_raw     (bus_raw_ff),
      .config_now  (config_now_ff),
      .result      (calc_result)
   );

   // Input register
   always_comb begin
      in_valid_in    = in_valid_ff;
      current_raw_in = current_raw_ff;
      bus_raw_in     = bus_raw_ff;
      config_now_in  = config_now_ff;
      if (req_fire) begin
         in_valid_in    = 1'b1;
         current_raw_in = req_current_raw;
         bus_raw_in     = req_bus_raw;
         config_now_in  = req_config_now;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register
   always_comb begin
      out_valid_in = out_valid_ff;
      result_in    = result_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         result_in    = calc_result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      current_raw_ff <= current_raw_in;
      bus_raw_ff     <= bus_raw_in;
      config_now_ff  <= config_now_in;
      result_ff      <= result_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_calibration_word = result_ff.calibration_word;
   assign rsp_config_word      = result_ff.config_word;
   assign rsp_range_code       = result_ff.range_code;

endmodule

// ===== design/csar_checker.sv =====
module csar_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_calibration_word,
   input logic [15:0] rsp_config_word,
   input logic [2:0]  rsp_range_code
);

   // No response right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Range code stays within the five ranges
   a_range_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_range_code <= csar_pkg::RANGE_3200MA))
      else $error("illegal range code");

   // Calibration word matches the range code
   a_calib_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_calibration_word == csar_pkg::calib_word(rsp_range_code)))
      else $error("calibration word does not match range");

   // Gain field matches the range code
   a_gain_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_config_word[12:11] == csar_pkg::gain_bits(rsp_range_code)))
      else $error("gain field does not match range");

   // A stalled response stays valid and holds its config word and range code
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_config_word)
                                  && $stable(rsp_range_code))
      else $error("stalled response changed");

endmodule

bind current_sensor_auto_ranger csar_checker u_csar_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_calibration_word (rsp_calibration_word),
   .rsp_config_word      (rsp_config_word),
   .rsp_range_code       (rsp_range_code)
);
